// ===== rtl/core/event_rate_window_meter_assert.svh =====
// Assertion macros for the event rate window meter
`ifndef EVENT_RATE_WINDOW_METER_ASSERT_SVH
`define EVENT_RATE_WINDOW_METER_ASSERT_SVH

// same-cycle implication under reset
`define ERWM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("erwm check failed");

// next-cycle implication under reset
`define ERWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("erwm check failed");

`endif

// ===== rtl/core/erwm_pkg.sv =====
// Shared types, constants and helpers of the event rate window meter
`default_nettype none
package erwm_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int TIME_BITS_DEF = 48;
    localparam int REG_W         = 27;
    localparam int CNT_OUT_W     = 11;
    localparam int MS_W          = 17;
    localparam int FREQ_W        = 28;
    localparam int DIV_W         = 64;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int MS_IN_W       = 27;
    localparam int MS_RECIP_W    = 28;
    localparam int MS_PROD_W     = MS_IN_W + MS_RECIP_W;
    localparam int MS_SHIFT      = 37;

    localparam logic [MS_W-1:0]       MS_MAX     = 17'd100000;
    localparam logic [FREQ_W-1:0]     FREQ_NUM   = 28'd256000000;
    localparam logic [DIV_W-1:0]      US_PER_MS  = 64'd1000;
    localparam logic [DIV_W-1:0]      MS_SAT_US  = 64'd100000000;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP   = 28'd137438954;

    localparam logic [2:0] REG_WIN_ONE  = 3'd0;
    localparam logic [2:0] REG_WIN_TWO  = 3'd1;
    localparam logic [2:0] REG_WIN_FIVE = 3'd2;
    localparam logic [2:0] REG_RETAIN   = 3'd3;
    localparam logic [2:0] REG_DELAY    = 3'd4;
    localparam logic [2:0] REG_RECENT   = 3'd5;

    localparam logic [REG_W-1:0] WIN_ONE_RST  = 27'd1000000;
    localparam logic [REG_W-1:0] WIN_TWO_RST  = 27'd2000000;
    localparam logic [REG_W-1:0] WIN_FIVE_RST = 27'd5000000;
    localparam logic [REG_W-1:0] RETAIN_RST   = 27'd10000000;
    localparam logic [REG_W-1:0] DELAY_RST    = 27'd2000000;
    localparam logic [REG_W-1:0] RECENT_RST   = 27'd500000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_WALK,
        ST_COMMIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic {
        SEL_AVG,
        SEL_FREQ
    } div_sel_t;

    typedef struct packed {
        logic [REG_W-1:0] win_one;
        logic [REG_W-1:0] win_two;
        logic [REG_W-1:0] win_five;
        logic [REG_W-1:0] retain;
        logic [REG_W-1:0] delay;
        logic [REG_W-1:0] recent;
    } cfg_t;

    typedef struct packed {
        logic     latch;
        logic     ev_write;
        logic     walk_start;
        logic     commit;
        logic     div_start;
        div_sel_t div_sel;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
        logic out_free;
    } stat_t;

    // scale microseconds to milliseconds by reciprocal multiply, saturate at the ms limit
    function automatic logic [MS_W-1:0] sat_ms(input logic [DIV_W-1:0] q);
        logic [MS_PROD_W-1:0] p;
        logic [MS_W-1:0]      r;
        p = MS_PROD_W'(q[MS_IN_W-1:0]) * MS_PROD_W'(MS_RECIP);
        r = (q >= MS_SAT_US) ? MS_MAX : p[MS_SHIFT +: MS_W];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/erwm_div.sv =====
// Restoring divider, one quotient bit per cycle
`default_nettype none
module erwm_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [erwm_pkg::DIV_W-1:0] dividend,
    input  wire logic [erwm_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [erwm_pkg::DIV_W-1:0]     quotient
);
    import erwm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   rem_s;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_s = {rem_reg, quo_reg[DIV_W-1]};
        trial = rem_s - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_s[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/erwm_ctrl.sv =====
// Sequencing state machine of the event rate window meter
`default_nettype none
module erwm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            action,
    output logic                 in_stall,
    input  wire erwm_pkg::stat_t stat,
    output erwm_pkg::cmd_t       cmd
);
    import erwm_pkg::*;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_AVG;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = action ? ST_WALK : ST_EVENT;
                end
            end
            ST_EVENT:    state_next = ST_IDLE;
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DIV_GO;
                sel_next   = SEL_AVG;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    unique case (sel_reg)
                        SEL_AVG:  sel_next = SEL_FREQ;
                        SEL_FREQ: sel_next = SEL_AVG;
                    endcase
                    state_next = (sel_reg == SEL_FREQ) ? ST_OUT : ST_DIV_GO;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        cmd.latch      = accept;
        cmd.walk_start = accept && action;
        cmd.ev_write   = (state_reg == ST_EVENT);
        cmd.commit     = (state_reg == ST_COMMIT);
        cmd.div_start  = (state_reg == ST_DIV_GO);
        cmd.load_out   = (state_reg == ST_OUT) && stat.out_free;
    end

endmodule
`default_nettype wire

// ===== rtl/core/erwm_dp.sv =====
// Timestamp ring, window walk, statistics and result register
`default_nettype none
module erwm_dp #(
    parameter int DEPTH     = erwm_pkg::DEPTH_DEF,
    parameter int TIME_BITS = erwm_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [TIME_BITS-1:0]          time_us,
    input  wire erwm_pkg::cfg_t                cfg,
    input  wire erwm_pkg::cmd_t                cmd,
    output erwm_pkg::stat_t                    stat,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_one,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_two,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_five,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_ten,
    output logic [erwm_pkg::MS_W-1:0]          min_interval_ms,
    output logic [erwm_pkg::MS_W-1:0]          avg_interval_ms,
    output logic [erwm_pkg::MS_W-1:0]          max_interval_ms,
    output logic [erwm_pkg::FREQ_W-1:0]        inst_freq_q8,
    output logic                               overflow
);
    import erwm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = TIME_BITS - REG_W;

    logic [TIME_BITS-1:0] store_mem [DEPTH];

    logic [TIME_BITS-1:0] now_reg;
    logic [AW-1:0]        oldest_reg, next_reg, iss_pos_reg;
    logic [CW-1:0]        count_reg, iss_cnt_reg, rd_idx_reg, drop_reg;
    logic                 ovf_reg, iss_act_reg, rdv_reg, bv_reg;
    logic [TIME_BITS-1:0] rd_data_reg;
    logic [TIME_BITS-1:0] l1_reg, l2_reg;
    logic                 have1_reg, have2_reg, b_h1_reg;
    logic [TIME_BITS-1:0] b_age_reg, b_lage_reg;
    logic [CW-1:0]        b1_reg, b2_reg, b5_reg, b10_reg, cntd_reg;
    logic [TIME_BITS-1:0] min_reg, max_reg;
    logic [DIV_W-1:0]     sum_reg;
    logic [MS_W-1:0]      avg_ms_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic                 out_v_reg;

    logic [TIME_BITS-1:0] age_a, lage_a, fresh_age, d_freq;
    logic                 expired_a, fresh;
    logic [DIV_W:0]       sum_add;
    logic [AW:0]          osum;
    logic [DIV_W-1:0]     dvd, dvs, quo;
    logic                 div_done;

    always_comb
    begin
        age_a     = (now_reg >= rd_data_reg) ? now_reg - rd_data_reg : '0;
        lage_a    = (rd_data_reg >= l1_reg) ? rd_data_reg - l1_reg : '0;
        expired_a = age_a > {{PW{1'b0}}, cfg.retain};
        sum_add   = {1'b0, sum_reg} + (DIV_W + 1)'(b_lage_reg);
        osum      = {1'b0, oldest_reg} + (AW + 1)'(drop_reg);
        fresh_age = (now_reg >= l1_reg) ? now_reg - l1_reg : '0;
        fresh     = have2_reg && (fresh_age < {{PW{1'b0}}, cfg.recent});
        d_freq    = (l1_reg >= l2_reg) ? l1_reg - l2_reg : '0;
    end

    always_comb
    begin
        dvd = US_PER_MS;
        dvs = US_PER_MS;
        unique case (cmd.div_sel)
            SEL_AVG:
            begin
                dvd = sum_reg;
                dvs = DIV_W'(cntd_reg);
            end
            SEL_FREQ:
            begin
                dvd = DIV_W'(FREQ_NUM);
                dvs = DIV_W'(d_freq);
            end
        endcase
    end

    erwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ev_write && (count_reg != CW'(DEPTH)))
        begin
            store_mem[next_reg] <= now_reg;
        end
        if (iss_act_reg)
        begin
            rd_data_reg <= store_mem[iss_pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg  <= '0;
            next_reg    <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            iss_act_reg <= 1'b0;
            rdv_reg     <= 1'b0;
            bv_reg      <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.ev_write)
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    next_reg  <= (next_reg == AW'(DEPTH - 1)) ? '0 : next_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                count_reg  <= count_reg - drop_reg;
                oldest_reg <= (osum >= (AW + 1)'(DEPTH)) ?
                              AW'(osum - (AW + 1)'(DEPTH)) : osum[AW-1:0];
            end
            if (cmd.walk_start)
            begin
                iss_act_reg <= (count_reg != '0);
            end
            else if (iss_act_reg && (iss_cnt_reg + 1'b1 == count_reg))
            begin
                iss_act_reg <= 1'b0;
            end
            rdv_reg <= iss_act_reg;
            bv_reg  <= rdv_reg && !expired_a;
            if (cmd.load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            now_reg <= time_us;
        end
        if (cmd.walk_start)
        begin
            iss_pos_reg <= oldest_reg;
            iss_cnt_reg <= '0;
            drop_reg    <= '0;
            have1_reg   <= 1'b0;
            have2_reg   <= 1'b0;
            l1_reg      <= '0;
            l2_reg      <= '0;
            b1_reg      <= '0;
            b2_reg      <= '0;
            b5_reg      <= '0;
            b10_reg     <= '0;
            cntd_reg    <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (iss_act_reg)
            begin
                iss_pos_reg <= (iss_pos_reg == AW'(DEPTH - 1)) ? '0 : iss_pos_reg + 1'b1;
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
                rd_idx_reg  <= iss_cnt_reg;
            end
            if (rdv_reg)
            begin
                if (expired_a)
                begin
                    drop_reg <= rd_idx_reg + 1'b1;
                end
                else
                begin
                    b_age_reg  <= age_a;
                    b_lage_reg <= lage_a;
                    b_h1_reg   <= have1_reg;
                    l2_reg     <= l1_reg;
                    have2_reg  <= have1_reg;
                    l1_reg     <= rd_data_reg;
                    have1_reg  <= 1'b1;
                end
            end
            if (bv_reg)
            begin
                b10_reg <= b10_reg + 1'b1;
                if (b_age_reg < {{PW{1'b0}}, cfg.win_five})
                begin
                    b5_reg <= b5_reg + 1'b1;
                end
                if (b_age_reg < {{PW{1'b0}}, cfg.win_two})
                begin
                    b2_reg <= b2_reg + 1'b1;
                end
                if (b_age_reg < {{PW{1'b0}}, cfg.win_one})
                begin
                    b1_reg <= b1_reg + 1'b1;
                end
                if (b_h1_reg && (b_age_reg < {{PW{1'b0}}, cfg.delay}))
                begin
                    if ((min_reg == '0) || (b_lage_reg < min_reg))
                    begin
                        min_reg <= b_lage_reg;
                    end
                    if ((max_reg == '0) || (b_lage_reg > max_reg))
                    begin
                        max_reg <= b_lage_reg;
                    end
                    sum_reg  <= sum_add[DIV_W] ? '1 : sum_add[DIV_W-1:0];
                    cntd_reg <= cntd_reg + 1'b1;
                end
            end
        end
        if (div_done)
        begin
            unique case (cmd.div_sel)
                SEL_AVG:  avg_ms_reg <= (cntd_reg == '0) ? '0 : sat_ms(quo);
                SEL_FREQ: freq_reg   <= !fresh ? '0 :
                                        (d_freq == '0) ? FREQ_NUM : quo[FREQ_W-1:0];
            endcase
        end
        if (cmd.load_out)
        begin
            count_one       <= CNT_OUT_W'(b1_reg);
            count_two       <= CNT_OUT_W'(b2_reg);
            count_five      <= CNT_OUT_W'(b5_reg);
            count_ten       <= CNT_OUT_W'(b10_reg);
            min_interval_ms <= sat_ms(DIV_W'(min_reg));
            avg_interval_ms <= avg_ms_reg;
            max_interval_ms <= sat_ms(DIV_W'(max_reg));
            inst_freq_q8    <= freq_reg;
            overflow        <= ovf_reg;
        end
    end

    assign out_valid      = out_v_reg;
    assign stat.walk_done = !iss_act_reg && !rdv_reg && !bv_reg;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_v_reg || !out_stall;

endmodule
`default_nettype wire

// ===== rtl/core/event_rate_window_meter.sv =====
// An event item stores its timestamp; an update walks the stored events and divides twice.
// The walk reads one ring entry per cycle from the timestamp memory.
// Mean and frequency share one 64-bit radix-2 divider in turn; ms scaling is a multiply.
// One item at a time; a finished result waits in the output register.
// Reset clears control, ring pointers and overflow; config registers take reset values.
// Ring contents are undefined after reset and are only read once written.
`default_nettype none
module event_rate_window_meter #(
    parameter int DEPTH     = erwm_pkg::DEPTH_DEF,
    parameter int TIME_BITS = erwm_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [TIME_BITS-1:0]          time_us,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_one,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_two,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_five,
    output logic [erwm_pkg::CNT_OUT_W-1:0]     count_ten,
    output logic [erwm_pkg::MS_W-1:0]          min_interval_ms,
    output logic [erwm_pkg::MS_W-1:0]          avg_interval_ms,
    output logic [erwm_pkg::MS_W-1:0]          max_interval_ms,
    output logic [erwm_pkg::FREQ_W-1:0]        inst_freq_q8,
    output logic                               overflow,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [erwm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [erwm_pkg::DATA_W-1:0]   pwdata,
    output logic [erwm_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import erwm_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    stat_t      stat;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [4:0] cmd_bits;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign wr_en    = psel && penable && pwrite;
    assign cmd_bits = {cmd.ev_write, cmd.walk_start, cmd.commit, cmd.div_start, cmd.load_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_one  <= WIN_ONE_RST;
            cfg_reg.win_two  <= WIN_TWO_RST;
            cfg_reg.win_five <= WIN_FIVE_RST;
            cfg_reg.retain   <= RETAIN_RST;
            cfg_reg.delay    <= DELAY_RST;
            cfg_reg.recent   <= RECENT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WIN_ONE:  cfg_reg.win_one  <= pwdata[REG_W-1:0];
                REG_WIN_TWO:  cfg_reg.win_two  <= pwdata[REG_W-1:0];
                REG_WIN_FIVE: cfg_reg.win_five <= pwdata[REG_W-1:0];
                REG_RETAIN:   cfg_reg.retain   <= pwdata[REG_W-1:0];
                REG_DELAY:    cfg_reg.delay    <= pwdata[REG_W-1:0];
                REG_RECENT:   cfg_reg.recent   <= pwdata[REG_W-1:0];
                default:      cfg_reg.win_one  <= cfg_reg.win_one;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WIN_ONE:  prdata = DATA_W'(cfg_reg.win_one);
            REG_WIN_TWO:  prdata = DATA_W'(cfg_reg.win_two);
            REG_WIN_FIVE: prdata = DATA_W'(cfg_reg.win_five);
            REG_RETAIN:   prdata = DATA_W'(cfg_reg.retain);
            REG_DELAY:    prdata = DATA_W'(cfg_reg.delay);
            REG_RECENT:   prdata = DATA_W'(cfg_reg.recent);
            default:      prdata = '0;
        endcase
    end

    erwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    erwm_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .time_us         (time_us),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .stat            (stat),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .count_one       (count_one),
        .count_two       (count_two),
        .count_five      (count_five),
        .count_ten       (count_ten),
        .min_interval_ms (min_interval_ms),
        .avg_interval_ms (avg_interval_ms),
        .max_interval_ms (max_interval_ms),
        .inst_freq_q8    (inst_freq_q8),
        .overflow        (overflow)
    );

`include "event_rate_window_meter_assert.svh"

    `ERWM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ERWM_ASSERT_NOW(a_load_only_free, clk, rst_n, cmd.load_out, !(out_valid && out_stall))
    `ERWM_ASSERT_NOW(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd_bits))

endmodule
`default_nettype wire

// ===== bench/event_rate_window_meter_test.sv =====
// Testbench for the event rate window meter: predicts every update result and checks it
`default_nettype none
module event_rate_window_meter_test;
    import erwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 1024;
    localparam int TB = 48;
    localparam int ACT_EVENT = 0;
    localparam int ACT_UPDATE = 1;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [10:0] c1;
        logic [10:0] c2;
        logic [10:0] c5;
        logic [10:0] c10;
        logic [16:0] mn;
        logic [16:0] av;
        logic [16:0] mx;
        logic [27:0] fq;
        logic        ov;
    } rate_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [TB-1:0] time_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [10:0] count_one, count_two, count_five, count_ten;
    logic [16:0] min_interval_ms, avg_interval_ms, max_interval_ms;
    logic [27:0] inst_freq_q8;
    logic overflow;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    event_rate_window_meter dut (.*);

    always #1 clk = ~clk;

    logic [TB-1:0] ring_ts [RING];
    int unsigned ring_head, ring_tail, ring_fill;
    logic ring_ovf;
    logic [26:0] win [6];
    rate_t expected_rates [$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;
    longint cycles = 0;
    logic [TB-1:0] clock_now = '0;

    function automatic logic [63:0] age_of(logic [63:0] a, logic [63:0] b);
        return a >= b ? a - b : 64'd0;
    endfunction

    function automatic logic [16:0] ms_of(logic [63:0] us);
        logic [63:0] m;
        m = us / 1000;
        return m > 100000 ? 17'd100000 : m[16:0];
    endfunction

    function automatic rate_t evaluate(logic [TB-1:0] now);
        rate_t r;
        int unsigned drop, b1, b2, b5, b10, nd, p;
        logic [63:0] l1, l2, mind, maxd, tot, ts, age, lg, fq;
        bit h1, h2;
        drop = 0; b1 = 0; b2 = 0; b5 = 0; b10 = 0; nd = 0;
        l1 = 0; l2 = 0; mind = 0; maxd = 0; tot = 0; fq = 0; h1 = 0; h2 = 0;
        p = ring_head;
        for (int i = 0; i < ring_fill; i++) begin
            ts = ring_ts[p];
            age = age_of(now, ts);
            p = (p + 1) % RING;
            if (age > win[REG_RETAIN]) begin
                drop = i + 1;
                continue;
            end
            b10++;
            if (age < win[REG_WIN_FIVE]) b5++;
            if (age < win[REG_WIN_TWO]) b2++;
            if (age < win[REG_WIN_ONE]) b1++;
            if (h1 && age < win[REG_DELAY]) begin
                lg = age_of(ts, l1);
                if (mind == 0 || lg < mind) mind = lg;
                if (maxd == 0 || lg > maxd) maxd = lg;
                tot = (tot + lg < tot) ? '1 : tot + lg;
                nd++;
            end
            l2 = l1; h2 = h1; l1 = ts; h1 = 1;
        end
        ring_head = (ring_head + drop) % RING;
        ring_fill -= drop;
        if (h2 && age_of(now, l1) < win[REG_RECENT]) begin
            lg = age_of(l1, l2);
            fq = lg == 0 ? 64'd256000000 : 64'd256000000 / lg;
        end
        r.c1 = 11'(b1); r.c2 = 11'(b2); r.c5 = 11'(b5); r.c10 = 11'(b10);
        r.mn = ms_of(mind);
        r.av = nd ? ms_of(tot / nd) : 17'd0;
        r.mx = ms_of(maxd);
        r.fq = fq[27:0];
        r.ov = ring_ovf;
        return r;
    endfunction

    task automatic send_item(int act, logic [TB-1:0] t);
        @(negedge clk);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
        in_valid <= 1'b1;
        action <= act[0];
        time_us <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (act == ACT_EVENT) begin
            if (ring_fill >= RING) ring_ovf = 1'b1;
            else begin
                ring_ts[ring_tail] = t;
                ring_tail = (ring_tail + 1) % RING;
                ring_fill++;
            end
        end else
            expected_rates.push_back(evaluate(t));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_rates.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < 6) win[idx] = val[26:0];
    endtask

    task automatic step_time(int unsigned lo, int unsigned hi);
        clock_now = clock_now + $urandom_range(hi, lo);
    endtask

    always @(posedge clk) begin
        rate_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("event_rate_window_meter_test: FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rates.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_rates.pop_front();
                if (count_one !== e.c1) begin $error("count_one exp %0d got %0d", e.c1, count_one); errors++; end
                if (count_two !== e.c2) begin $error("count_two exp %0d got %0d", e.c2, count_two); errors++; end
                if (count_five !== e.c5) begin $error("count_five exp %0d got %0d", e.c5, count_five); errors++; end
                if (count_ten !== e.c10) begin $error("count_ten exp %0d got %0d", e.c10, count_ten); errors++; end
                if (min_interval_ms !== e.mn) begin $error("min_interval_ms exp %0d got %0d", e.mn, min_interval_ms); errors++; end
                if (avg_interval_ms !== e.av) begin $error("avg_interval_ms exp %0d got %0d", e.av, avg_interval_ms); errors++; end
                if (max_interval_ms !== e.mx) begin $error("max_interval_ms exp %0d got %0d", e.mx, max_interval_ms); errors++; end
                if (inst_freq_q8 !== e.fq) begin $error("inst_freq_q8 exp %0d got %0d", e.fq, inst_freq_q8); errors++; end
                if (overflow !== e.ov) begin $error("overflow exp %0d got %0d", e.ov, overflow); errors++; end
            end
        end
    end

    always @(negedge clk) out_stall <= recv_idle > 0 && $urandom_range(99) < recv_idle;

    task automatic test_defaults();
        send_item(ACT_UPDATE, '0);
        send_item(ACT_EVENT, 48'd100);
        send_item(ACT_EVENT, 48'd100);
        send_item(ACT_UPDATE, 48'd200);
        send_item(ACT_EVENT, 48'd300000);
        send_item(ACT_EVENT, 48'd50);
        send_item(ACT_UPDATE, 48'd400000);
        send_item(ACT_UPDATE, 48'd20);
        send_item(ACT_UPDATE, 48'd12000000);
        clock_now = 48'd12000000;
    endtask

    task automatic test_extremes();
        write_reg(REG_WIN_ONE, 32'd0);
        write_reg(REG_WIN_TWO, 32'hFFFF_FFFF);
        write_reg(REG_WIN_FIVE, 32'd1);
        write_reg(REG_RETAIN, 32'd100000000);
        write_reg(REG_DELAY, 32'd100000000);
        write_reg(REG_RECENT, 32'd100000000);
        write_reg(7, 32'd5);
        send_item(ACT_EVENT, clock_now);
        send_item(ACT_EVENT, clock_now + 48'd99000000);
        send_item(ACT_EVENT, clock_now + 48'd99000001);
        send_item(ACT_UPDATE, clock_now + 48'd99000001);
        clock_now = '1 - 48'd200000000;
        send_item(ACT_EVENT, clock_now);
        send_item(ACT_UPDATE, '1);
        send_item(ACT_UPDATE, '1);
        send_item(ACT_EVENT, '1);
        send_item(ACT_UPDATE, '1);
        clock_now = '0;
    endtask

    task automatic test_overflow();
        write_reg(REG_RETAIN, 32'd100000000);
        write_reg(REG_DELAY, 32'd3000);
        write_reg(REG_RECENT, 32'd1);
        for (int i = 0; i < 1030; i++) begin
            step_time(0, 3);
            send_item(ACT_EVENT, clock_now);
        end
        send_item(ACT_UPDATE, clock_now);
        clock_now += 48'd200000000;
        send_item(ACT_UPDATE, clock_now);
    endtask

    task automatic test_random(int n);
        int k;
        write_reg(REG_WIN_ONE, $urandom_range(3000, 1));
        write_reg(REG_WIN_TWO, $urandom_range(8000, 1000));
        write_reg(REG_WIN_FIVE, $urandom_range(20000, 2000));
        write_reg(REG_RETAIN, $urandom_range(40000, 5000));
        write_reg(REG_DELAY, $urandom_range(10000, 1));
        write_reg(REG_RECENT, $urandom);
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) < 7) begin
                step_time(0, 1500);
                send_item(ACT_EVENT, clock_now);
            end else begin
                step_time(0, 800);
                send_item(ACT_UPDATE, clock_now);
            end
            k++;
        end
    endtask

    initial begin
        ring_head = 0; ring_tail = 0; ring_fill = 0; ring_ovf = 0;
        win[0] = WIN_ONE_RST; win[1] = WIN_TWO_RST; win[2] = WIN_FIVE_RST;
        win[3] = RETAIN_RST; win[4] = DELAY_RST; win[5] = RECENT_RST;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_defaults();
        test_extremes();
        send_idle = 16; recv_idle = 47;
        test_random(180);
        send_idle = 47; recv_idle = 16;
        test_random(180);
        send_idle = 0; recv_idle = 0;
        test_random(180);
        test_overflow();
        drain();
        if (errors == 0)
            $display("event_rate_window_meter_test: PASS");
        else
            $display("event_rate_window_meter_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
